@@ rtl/hierarchical_timer_wheel_assert.svh @@
// assertion macros shared by the timer wheel modules
`ifndef HIERARCHICAL_TIMER_WHEEL_ASSERT_SVH
`define HIERARCHICAL_TIMER_WHEEL_ASSERT_SVH
`ifndef SYNTHESIS
`define HTW_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
`define HTW_NEVER(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);
`else
`define HTW_ASSERT(lbl, prop, msg)
`define HTW_NEVER(lbl, expr, msg)
`endif
`endif

@@ rtl/htw_pkg.sv @@
// types, constants and placement functions of the timer wheel
package htw_pkg;

   localparam int NUM_TIMERS       = 32;
   localparam int LOW_LEVEL_BITS   = 8;
   localparam int UPPER_LEVEL_BITS = 6;
   localparam int MAX_REPORTS      = 32;

   localparam int IDX_W  = $clog2(NUM_TIMERS);
   localparam int SLOT_W = (LOW_LEVEL_BITS > UPPER_LEVEL_BITS) ? LOW_LEVEL_BITS
                                                               : UPPER_LEVEL_BITS;
   localparam int REP_W  = $clog2(MAX_REPORTS + 1);
   localparam int LVL_W  = 3;

   localparam logic [LVL_W-1:0] LEVEL_LOW = 3'd0;
   localparam logic [LVL_W-1:0] LEVEL_ONE = 3'd1;
   localparam logic [LVL_W-1:0] LEVEL_TWO = 3'd2;
   localparam logic [LVL_W-1:0] LEVEL_THREE = 3'd3;
   localparam logic [LVL_W-1:0] LEVEL_TOP = 3'd4;

   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_START = 2'd1;
   localparam logic [1:0] OP_KILL  = 2'd2;

   localparam logic [1:0] KIND_ACK  = 2'd0;
   localparam logic [1:0] KIND_FIRE = 2'd1;
   localparam logic [1:0] KIND_IDLE = 2'd2;

   typedef struct packed {
      logic [1:0]         op;
      logic [4:0]         timer_id;
      logic [30:0]        first_delay;
      logic [30:0]        reload_period;
      logic signed [31:0] repeat_count;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [4:0] fired_id;
      logic       rearmed;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [31:0]       expiry;
      logic [30:0]       period;
      logic [31:0]       count;
      logic [LVL_W-1:0]  level;
      logic [SLOT_W-1:0] slot;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic [LVL_W-1:0]  level;
      logic [SLOT_W-1:0] slot;
   } place_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CASC,
      ST_FIRE,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic accept;
      logic scan_start;
      logic fire_enter;
      logic lvl_next;
      logic fire_end;
      logic flush;
   } ctl_cmd_type;

   typedef struct packed {
      logic req_is_tick;
      logic tick_zero;
      logic scan_done;
      logic casc_more;
      logic out_free;
   } ctl_sts_type;

   function automatic logic [UPPER_LEVEL_BITS-1:0] upper_field(logic [31:0] v, int sh);
      logic [63:0] w;
      w = {32'd0, v} >> sh;
      return w[UPPER_LEVEL_BITS-1:0];
   endfunction

   // slot index of an upper level at time t
   function automatic logic [SLOT_W-1:0] level_field(logic [31:0] t, logic [LVL_W-1:0] lvl);
      logic [SLOT_W-1:0] s;
      unique case (lvl)
         LEVEL_ONE:   s = SLOT_W'(upper_field(t, LOW_LEVEL_BITS));
         LEVEL_TWO:   s = SLOT_W'(upper_field(t, LOW_LEVEL_BITS + UPPER_LEVEL_BITS));
         LEVEL_THREE: s = SLOT_W'(upper_field(t, LOW_LEVEL_BITS + 2 * UPPER_LEVEL_BITS));
         default:     s = SLOT_W'(upper_field(t, LOW_LEVEL_BITS + 3 * UPPER_LEVEL_BITS));
      endcase
      return s;
   endfunction

   // level and slot for expiry e, diff = e - t
   function automatic place_type place_fn(logic [31:0] e, logic [31:0] diff,
                                          logic [31:0] t);
      logic [63:0] d;
      place_type   p;
      d       = {32'd0, diff};
      p.level = LEVEL_TOP;
      p.slot  = SLOT_W'(upper_field(e, LOW_LEVEL_BITS + 3 * UPPER_LEVEL_BITS));
      for (int k = 3; k >= 1; k--) begin
         if ((d >> (LOW_LEVEL_BITS + k * UPPER_LEVEL_BITS)) == 64'd0) begin
            p.level = LVL_W'(k);
            p.slot  = SLOT_W'(upper_field(e, LOW_LEVEL_BITS + (k - 1) * UPPER_LEVEL_BITS));
         end
      end
      if ((d >> LOW_LEVEL_BITS) == 64'd0) begin
         p.level = LEVEL_LOW;
         p.slot  = SLOT_W'(e[LOW_LEVEL_BITS-1:0]);
      end
      if (diff[31]) begin
         p.level = LEVEL_LOW;
         p.slot  = SLOT_W'(t[LOW_LEVEL_BITS-1:0]);
      end
      return p;
   endfunction

endpackage

@@ rtl/htw_ram.sv @@
// generic single write port ram with registered read
module htw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/htw_ctrl.sv @@
// sequencing state machine of the timer wheel
`include "hierarchical_timer_wheel_assert.svh"
module htw_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  htw_pkg::ctl_sts_type sts,
   output htw_pkg::ctl_cmd_type cmd
);
   import htw_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (!sts.req_is_tick) begin
                  state_in = ST_FLUSH;
               end else if (sts.tick_zero) begin
                  state_in = ST_CASC;
               end else begin
                  state_in = ST_FIRE;
               end
            end
         end
         ST_CASC: begin
            if (sts.scan_done && !sts.casc_more) begin
               state_in = ST_FIRE;
            end
         end
         ST_FIRE: begin
            if (sts.scan_done) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (sts.req_is_tick) begin
                  cmd.scan_start = 1'b1;
                  cmd.fire_enter = !sts.tick_zero;
               end
            end
         end
         ST_CASC: begin
            if (sts.scan_done) begin
               cmd.scan_start = 1'b1;
               cmd.lvl_next   = sts.casc_more;
               cmd.fire_enter = !sts.casc_more;
            end
         end
         ST_FIRE: begin
            cmd.fire_end = sts.scan_done;
         end
         ST_FLUSH: begin
            cmd.flush = sts.out_free;
         end
         default: cmd = '0;
      endcase
   end

   `HTW_ASSERT(a_flush_done, (state_ff == ST_FLUSH && sts.out_free) |=> state_ff == ST_IDLE, "flush did not return to idle")
   `HTW_ASSERT(a_tick_scans, (cmd.accept && sts.req_is_tick) |=> (state_ff == ST_CASC || state_ff == ST_FIRE), "tick did not start a scan")
   `HTW_ASSERT(a_casc_holds, (state_ff == ST_CASC && !sts.scan_done) |=> state_ff == ST_CASC, "cascade left before scan end")

endmodule

@@ rtl/htw_dpath.sv @@
// timer table, wheel placement, scan pipeline and result registers
`include "hierarchical_timer_wheel_assert.svh"
module htw_dpath (
   input  logic                 clock,
   input  logic                 reset,
   input  htw_pkg::req_type     req_data,
   input  htw_pkg::ctl_cmd_type cmd,
   output htw_pkg::ctl_sts_type sts,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output htw_pkg::rsp_type     rsp_data
);
   import htw_pkg::*;

   logic [31:0]               time_ff, time_in;
   logic [NUM_TIMERS-1:0]     armed_ff, armed_in;
   logic [LOW_LEVEL_BITS-1:0] tick_idx_ff, tick_idx_in;
   logic [LVL_W-1:0]          casc_lvl_ff, casc_lvl_in;
   logic                      fire_mode_ff, fire_mode_in;
   logic                      issue_ff, issue_in;
   logic [IDX_W-1:0]          rd_cnt_ff, rd_cnt_in;
   logic                      pend_ff, pend_in;
   logic [IDX_W-1:0]          pend_idx_ff, pend_idx_in;
   logic [REP_W-1:0]          rep_cnt_ff, rep_cnt_in;
   logic                      hold_valid_ff, hold_valid_in;
   rsp_type                   hold_ff, hold_in;
   logic                      out_valid_ff, out_valid_in;
   rsp_type                   out_ff, out_in;

   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   entry_type          wr_entry;
   logic               rd_en;
   logic [ENTRY_W-1:0] rd_bits;
   entry_type          ent;

   logic              id_ok, start_wr, kill_wr;
   logic [IDX_W-1:0]  req_idx;
   logic [31:0]       start_exp;
   logic [SLOT_W-1:0] casc_slot;
   logic              armed_cur, casc_hit, fire_hit, do_fire, want_report;
   logic              out_free, stall, advance, report, push;
   logic [31:0]       new_exp, diff_casc, diff_fire;
   place_type         p_start, p_casc, p_fire;

   htw_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_TIMERS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_cnt_ff),
      .rd_data (rd_bits)
   );

   assign ent = entry_type'(rd_bits);

   // entry evaluation
   always_comb begin
      id_ok     = 32'(req_data.timer_id) < NUM_TIMERS;
      req_idx   = IDX_W'(req_data.timer_id);
      start_wr  = cmd.accept && (req_data.op == OP_START) && id_ok;
      kill_wr   = cmd.accept && (req_data.op == OP_KILL) && id_ok;
      start_exp = time_ff + {1'b0, req_data.first_delay};
      p_start   = place_fn(start_exp, {1'b0, req_data.first_delay}, time_ff);

      casc_slot = level_field(time_ff, casc_lvl_ff);
      armed_cur = armed_ff[pend_idx_ff];
      casc_hit  = pend_ff && !fire_mode_ff && armed_cur &&
                  (ent.level == casc_lvl_ff) && (ent.slot == casc_slot);
      fire_hit  = pend_ff && fire_mode_ff && armed_cur && (ent.level == LEVEL_LOW) &&
                  (ent.slot == SLOT_W'(tick_idx_ff));
      do_fire   = fire_hit && (ent.count[31] || (ent.count != 32'd0));
      new_exp   = ent.expiry + {1'b0, ent.period};
      diff_casc = ent.expiry - time_ff;
      diff_fire = new_exp - time_ff;
      p_casc    = place_fn(ent.expiry, diff_casc, time_ff);
      p_fire    = place_fn(new_exp, diff_fire, time_ff);

      want_report = do_fire && (rep_cnt_ff < REP_W'(MAX_REPORTS));
      out_free    = !out_valid_ff || rsp_ready;
      stall       = want_report && hold_valid_ff && !out_free;
      advance     = !stall;
      report      = want_report && advance;
      push        = (report && hold_valid_ff) || cmd.flush;
   end

   // table writes
   always_comb begin
      wr_en    = 1'b0;
      wr_addr  = pend_idx_ff;
      wr_entry = ent;
      if (start_wr) begin
         wr_en          = 1'b1;
         wr_addr        = req_idx;
         wr_entry.expiry = start_exp;
         wr_entry.period = req_data.reload_period;
         wr_entry.count  = req_data.repeat_count;
         wr_entry.level  = p_start.level;
         wr_entry.slot   = p_start.slot;
      end else if (casc_hit) begin
         wr_en          = 1'b1;
         wr_entry.level = p_casc.level;
         wr_entry.slot  = p_casc.slot;
      end else if (do_fire && advance) begin
         wr_en           = 1'b1;
         wr_entry.expiry = new_exp;
         wr_entry.count  = ent.count[31] ? ent.count : ent.count - 32'd1;
         wr_entry.level  = p_fire.level;
         wr_entry.slot   = p_fire.slot;
      end
   end

   // control state next values
   always_comb begin
      time_in      = time_ff;
      armed_in     = armed_ff;
      tick_idx_in  = tick_idx_ff;
      casc_lvl_in  = casc_lvl_ff;
      fire_mode_in = fire_mode_ff;
      issue_in     = issue_ff;
      rd_cnt_in    = rd_cnt_ff;
      pend_in      = pend_ff;
      pend_idx_in  = pend_idx_ff;
      rep_cnt_in   = rep_cnt_ff;
      rd_en        = 1'b0;

      if (start_wr) begin
         armed_in[req_idx] = 1'b1;
      end
      if (kill_wr) begin
         armed_in[req_idx] = 1'b0;
      end
      // count used up: freed without firing
      if (fire_hit && !do_fire) begin
         armed_in[pend_idx_ff] = 1'b0;
      end

      if (cmd.accept) begin
         casc_lvl_in = LEVEL_ONE;
         rep_cnt_in  = '0;
      end
      if (cmd.lvl_next) begin
         casc_lvl_in = casc_lvl_ff + 3'd1;
      end
      if (cmd.fire_enter) begin
         time_in     = time_ff + 32'd1;
         tick_idx_in = time_ff[LOW_LEVEL_BITS-1:0];
      end
      if (report) begin
         rep_cnt_in = rep_cnt_ff + 1'b1;
      end

      if (cmd.scan_start) begin
         fire_mode_in = cmd.fire_enter;
         issue_in     = 1'b1;
         rd_cnt_in    = '0;
         pend_in      = 1'b0;
      end else if (advance) begin
         pend_in     = issue_ff;
         pend_idx_in = rd_cnt_ff;
         rd_en       = issue_ff;
         if (issue_ff) begin
            rd_cnt_in = rd_cnt_ff + 1'b1;
            if (rd_cnt_ff == IDX_W'(NUM_TIMERS - 1)) begin
               issue_in = 1'b0;
            end
         end
      end
   end

   // report staging: the newest report waits in hold until its last flag is known
   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;

      if (push) begin
         out_valid_in = 1'b1;
         out_in       = hold_ff;
         out_in.last  = cmd.flush;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end

      if (cmd.accept && (req_data.op == OP_START || req_data.op == OP_KILL)) begin
         hold_valid_in    = 1'b1;
         hold_in.kind     = KIND_ACK;
         hold_in.fired_id = req_data.timer_id;
         hold_in.rearmed  = 1'b0;
         hold_in.last     = 1'b0;
      end else if (report) begin
         hold_valid_in    = 1'b1;
         hold_in.kind     = KIND_FIRE;
         hold_in.fired_id = 5'(pend_idx_ff);
         hold_in.rearmed  = 1'b1;
         hold_in.last     = 1'b0;
      end else if (cmd.fire_end && !hold_valid_ff) begin
         hold_valid_in    = 1'b1;
         hold_in.kind     = KIND_IDLE;
         hold_in.fired_id = 5'd0;
         hold_in.rearmed  = 1'b0;
         hold_in.last     = 1'b0;
      end else if (cmd.flush) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff       <= '0;
         armed_ff      <= '0;
         fire_mode_ff  <= 1'b0;
         issue_ff      <= 1'b0;
         pend_ff       <= 1'b0;
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         time_ff       <= time_in;
         armed_ff      <= armed_in;
         fire_mode_ff  <= fire_mode_in;
         issue_ff      <= issue_in;
         pend_ff       <= pend_in;
         hold_valid_ff <= hold_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tick_idx_ff <= tick_idx_in;
      casc_lvl_ff <= casc_lvl_in;
      rd_cnt_ff   <= rd_cnt_in;
      pend_idx_ff <= pend_idx_in;
      rep_cnt_ff  <= rep_cnt_in;
      hold_ff     <= hold_in;
      out_ff      <= out_in;
   end

   always_comb begin
      sts.req_is_tick = !(req_data.op == OP_START || req_data.op == OP_KILL);
      sts.tick_zero   = time_ff[LOW_LEVEL_BITS-1:0] == '0;
      sts.scan_done   = !issue_ff && !pend_ff;
      sts.casc_more   = (casc_slot == '0) && (casc_lvl_ff != LEVEL_TOP);
      sts.out_free    = out_free;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   `HTW_NEVER(a_no_overwrite, push && out_valid_ff && !rsp_ready, "pending result overwritten")
   `HTW_ASSERT(a_stall_holds, stall |=> (pend_ff && $stable(pend_idx_ff)), "scan moved during stall")
   `HTW_NEVER(a_accept_empty, cmd.accept && hold_valid_ff, "item taken with a report still held")

endmodule

@@ rtl/hierarchical_timer_wheel.sv @@
// top level of the five-level hierarchical timer wheel
//
//   channel   direction   handshake              payload
//   req_      in          req_valid / req_ready  req_data  (op, id, delay, period, count)
//   rsp_      out         rsp_valid / rsp_ready  rsp_data  (kind, id, rearmed, last)
//
// start and kill: the acknowledge is staged in the hold register, then moved to the output register
// tick: one table scan over all NUM_TIMERS entries for the firing pass, plus one scan
//   per cascaded level when the low index is zero, up to five scans in all
// the scan rate is set by the single read port of the timer table
// reset clears time, armed flags and handshakes; table contents stay undefined
// a stalled result channel holds the firing scan; a new item is taken once the
//   last result of the previous one sits in the output register
`include "hierarchical_timer_wheel_assert.svh"
module hierarchical_timer_wheel (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  htw_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output htw_pkg::rsp_type  rsp_data
);
   import htw_pkg::*;

   // command and status between sequencer and datapath
   ctl_cmd_type cmd;
   ctl_sts_type sts;

   // sequencer: idle, cascade scans, firing scan, final flush
   htw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // timer table, placement logic and result staging
   htw_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // a transfer on the request side only ever starts one sequence
   `HTW_NEVER(a_ready_idle, req_ready && cmd.fire_end, "ready while a scan ends")
   `HTW_ASSERT(a_ack_follows, (req_valid && req_ready && !sts.req_is_tick) |=> !req_ready, "ack not sequenced")
   `HTW_ASSERT(a_scan_blocks, (req_valid && req_ready && sts.req_is_tick) |=> !req_ready, "tick not sequenced")

endmodule
